// ===== rtl/core/grr_pkg.sv =====
// shared constants and types of the gcd ratio reducer
// no dependencies; imported by every module of the block

package grr_pkg;

    // default operand width
    localparam int VALUE_WIDTH_DEF = 32;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // queue status seen by the front (full) and the back (empty)
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ===== rtl/core/grr_front.sv =====
// front end: accepts operand beats, orders the pair and flags the all-zero case
// depends on grr_pkg; feeds grr_fifo

module grr_front #(
    parameter int VALUE_WIDTH = grr_pkg::VALUE_WIDTH_DEF,
    parameter int IN_W        = 2 * VALUE_WIDTH,
    parameter int ENTRY_W     = 4 * VALUE_WIDTH + 1
) (
    input  logic                   i_tvalid,
    output logic                   o_tready,
    input  logic [IN_W-1:0]        i_tdata,
    input  grr_pkg::t_fifo_stat    i_fifo_stat,
    output logic                   o_push,
    output logic [ENTRY_W-1:0]     o_entry
);
    import grr_pkg::*;

    logic [VALUE_WIDTH-1:0] a_val;
    logic [VALUE_WIDTH-1:0] b_val;
    logic                   a_gt_b;
    logic                   both_zero;

    // operand fields, first value in the low bits
    assign a_val = i_tdata[0 +: VALUE_WIDTH];
    assign b_val = i_tdata[VALUE_WIDTH +: VALUE_WIDTH];

    // classify: order the pair, detect the all-zero pair
    assign a_gt_b    = (a_val > b_val);
    assign both_zero = (a_val == '0) && (b_val == '0);

    // accept while the queue has room
    assign o_tready = !i_fifo_stat.full;
    assign o_push   = i_tvalid && o_tready;

    // entry: a, b, larger, smaller, zero flag
    always_comb begin
        o_entry                                 = '0;
        o_entry[0 +: VALUE_WIDTH]               = a_val;
        o_entry[VALUE_WIDTH +: VALUE_WIDTH]     = b_val;
        o_entry[2*VALUE_WIDTH +: VALUE_WIDTH]   = a_gt_b ? a_val : b_val;
        o_entry[3*VALUE_WIDTH +: VALUE_WIDTH]   = a_gt_b ? b_val : a_val;
        o_entry[4*VALUE_WIDTH]                  = both_zero;
    end

endmodule

// ===== rtl/core/grr_fifo.sv =====
// short register queue between the front and back ends
// depends on grr_pkg for the status struct

module grr_fifo #(
    parameter int WIDTH = 4 * grr_pkg::VALUE_WIDTH_DEF + 1,
    parameter int DEPTH = grr_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_data,
    output grr_pkg::t_fifo_stat o_stat
);
    import grr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/grr_divider.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on grr_pkg; used by grr_back for remainder and quotient steps

module grr_divider #(
    parameter int VALUE_WIDTH = grr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [VALUE_WIDTH-1:0] o_remainder
);
    import grr_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_den;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   trial;
    logic                   fits;

    // trial subtraction of the divisor from the shifted partial remainder
    assign shifted = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign trial   = shifted - {1'b0, r_den};
    assign fits    = !trial[VALUE_WIDTH];

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            r_quo <= {r_quo[VALUE_WIDTH-2:0], fits};
        end
    end

endmodule

// ===== rtl/core/grr_back.sv =====
// back end: euclid loop and the two ratio divisions, output register
// depends on grr_pkg; drives grr_divider and pops grr_fifo

module grr_back #(
    parameter int VALUE_WIDTH = grr_pkg::VALUE_WIDTH_DEF,
    parameter int ENTRY_W     = 4 * VALUE_WIDTH + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [ENTRY_W-1:0]     i_entry,
    input  grr_pkg::t_fifo_stat    i_fifo_stat,
    output logic                   o_pop,
    output logic                   o_div_start,
    output logic [VALUE_WIDTH-1:0] o_div_dividend,
    output logic [VALUE_WIDTH-1:0] o_div_divisor,
    input  logic                   i_div_done,
    input  logic [VALUE_WIDTH-1:0] i_div_quotient,
    input  logic [VALUE_WIDTH-1:0] i_div_remainder,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH-1:0] o_ratio_first,
    output logic [VALUE_WIDTH-1:0] o_ratio_second,
    output logic [VALUE_WIDTH-1:0] o_common_divisor,
    output logic                   o_both_zero
);
    import grr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_GCD_WAIT,
        S_DA_WAIT,
        S_DB_WAIT,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_a;
    logic [VALUE_WIDTH-1:0] r_b;
    logic [VALUE_WIDTH-1:0] r_big;
    logic [VALUE_WIDTH-1:0] r_small;
    logic [VALUE_WIDTH-1:0] r_gcd;
    logic [VALUE_WIDTH-1:0] r_qa;
    logic [VALUE_WIDTH-1:0] r_qb;
    logic                   r_zero;
    logic                   r_div_start;
    logic [VALUE_WIDTH-1:0] r_div_dividend;
    logic [VALUE_WIDTH-1:0] r_div_divisor;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_first;
    logic [VALUE_WIDTH-1:0] r_out_second;
    logic [VALUE_WIDTH-1:0] r_out_gcd;
    logic                   r_out_zero;

    // take the next queued item when idle
    assign o_pop = (r_state == S_IDLE) && !i_fifo_stat.empty;

    assign o_div_start      = r_div_start;
    assign o_div_dividend   = r_div_dividend;
    assign o_div_divisor    = r_div_divisor;
    assign o_valid          = r_out_valid;
    assign o_ratio_first    = r_out_first;
    assign o_ratio_second   = r_out_second;
    assign o_common_divisor = r_out_gcd;
    assign o_both_zero      = r_out_zero;

    // sequencer with registered divider requests and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_fifo_stat.empty) begin
                        r_a     <= i_entry[0 +: VALUE_WIDTH];
                        r_b     <= i_entry[VALUE_WIDTH +: VALUE_WIDTH];
                        r_big   <= i_entry[2*VALUE_WIDTH +: VALUE_WIDTH];
                        r_small <= i_entry[3*VALUE_WIDTH +: VALUE_WIDTH];
                        r_zero  <= i_entry[4*VALUE_WIDTH];
                        r_state <= i_entry[4*VALUE_WIDTH] ? S_OUT : S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_small == '0) begin
                        // divisor found, start the first ratio division
                        r_gcd          <= r_big;
                        r_div_dividend <= r_a;
                        r_div_divisor  <= r_big;
                        r_div_start    <= 1'b1;
                        r_state        <= S_DA_WAIT;
                    end else begin
                        r_div_dividend <= r_big;
                        r_div_divisor  <= r_small;
                        r_div_start    <= 1'b1;
                        r_state        <= S_GCD_WAIT;
                    end
                end
                S_GCD_WAIT: begin
                    if (i_div_done) begin
                        r_big   <= r_small;
                        r_small <= i_div_remainder;
                        r_state <= S_GCD;
                    end
                end
                S_DA_WAIT: begin
                    if (i_div_done) begin
                        r_qa           <= i_div_quotient;
                        r_div_dividend <= r_b;
                        r_div_divisor  <= r_gcd;
                        r_div_start    <= 1'b1;
                        r_state        <= S_DB_WAIT;
                    end
                end
                S_DB_WAIT: begin
                    if (i_div_done) begin
                        r_qb    <= i_div_quotient;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_first  <= r_zero ? '0 : r_qa;
                        r_out_second <= r_zero ? '0 : r_qb;
                        r_out_gcd    <= r_zero ? '0 : r_gcd;
                        r_out_zero   <= r_zero;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/gcd_ratio_reducer_top.sv =====
// top level of the gcd ratio reducer: front end, queue, back end, divider
// depends on grr_pkg, grr_front, grr_fifo, grr_divider, grr_back

// Reduces a pair of unsigned values to their lowest ratio.
// Input stream: one beat carries first_value (low bits) and second_value.
// Output stream: one beat per input with ratio_first, ratio_second and
// common_divisor in tdata and the both-zero flag in tuser; when both
// operands are zero the flag is set and all data fields are zero.
// The front end classifies each pair and places it in a two-entry queue,
// so up to two pairs are taken while the back end is busy or the result
// register waits for the receiver.
// Cost per pair is set by the shared one-bit-per-cycle divider, which serves
// each division in turn: one per euclid remainder step and one per ratio
// field, so a pair that needs k remainder steps uses k+2 divisions
// (k=1 for many pairs, up to about 46 at 32 bits); a both-zero pair skips
// the divider. Pairs are handled one at a time.
// A stalled receiver holds the result register; the back end then waits,
// and once the queue fills the input ready drops.
// Reset is synchronous and empties the queue, the back end and the output.

module gcd_ratio_reducer_top #(
    parameter int VALUE_WIDTH = grr_pkg::VALUE_WIDTH_DEF,
    parameter int IN_DATA_W   = ((2 * VALUE_WIDTH + 7) / 8) * 8,
    parameter int OUT_DATA_W  = ((3 * VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // first_value, second_value, zero padding
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // ratio_first, ratio_second, common_divisor, zero padding
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // both_zero
    output logic                  o_m_axis_tuser
);
    import grr_pkg::*;

    localparam int ENTRY_W = 4 * VALUE_WIDTH + 1;

    t_fifo_stat             fifo_stat;
    logic                   push;
    logic                   pop;
    logic [ENTRY_W-1:0]     push_entry;
    logic [ENTRY_W-1:0]     head_entry;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_divisor;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [VALUE_WIDTH-1:0] div_remainder;
    logic [VALUE_WIDTH-1:0] ratio_first;
    logic [VALUE_WIDTH-1:0] ratio_second;
    logic [VALUE_WIDTH-1:0] common_divisor;

    grr_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .IN_W        (2 * VALUE_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_tdata     (i_s_axis_tdata[2*VALUE_WIDTH-1:0]),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    grr_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_stat  (fifo_stat)
    );

    grr_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    grr_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (head_entry),
        .i_fifo_stat      (fifo_stat),
        .o_pop            (pop),
        .o_div_start      (div_start),
        .o_div_dividend   (div_dividend),
        .o_div_divisor    (div_divisor),
        .i_div_done       (div_done),
        .i_div_quotient   (div_quotient),
        .i_div_remainder  (div_remainder),
        .o_valid          (o_m_axis_tvalid),
        .i_ready          (i_m_axis_tready),
        .o_ratio_first    (ratio_first),
        .o_ratio_second   (ratio_second),
        .o_common_divisor (common_divisor),
        .o_both_zero      (o_m_axis_tuser)
    );

    // pack result fields, first field in the low bits
    always_comb begin
        o_m_axis_tdata                                 = '0;
        o_m_axis_tdata[0 +: VALUE_WIDTH]               = ratio_first;
        o_m_axis_tdata[VALUE_WIDTH +: VALUE_WIDTH]     = ratio_second;
        o_m_axis_tdata[2*VALUE_WIDTH +: VALUE_WIDTH]   = common_divisor;
    end

endmodule

// ===== rtl/core/grr_checker.sv =====
// port-level checks of the gcd ratio reducer, bound to the top level
// depends on grr_pkg and gcd_ratio_reducer_top

module grr_checker #(
    parameter int VALUE_WIDTH = grr_pkg::VALUE_WIDTH_DEF,
    parameter int OUT_DATA_W  = ((3 * VALUE_WIDTH + 7) / 8) * 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tuser
);
    import grr_pkg::*;

    // nothing comes out of the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // the all-zero flag comes with all-zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("both_zero beat with nonzero data");

    // any other pair has a nonzero divisor
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata[2*VALUE_WIDTH +: VALUE_WIDTH] != '0)
        else $error("zero divisor on a nonzero pair");

    // a nonzero divisor never exceeds the larger ratio input, so ratios of one pair
    // cannot both be zero
    a_ratio_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            (o_m_axis_tdata[0 +: VALUE_WIDTH] != '0) ||
            (o_m_axis_tdata[VALUE_WIDTH +: VALUE_WIDTH] != '0))
        else $error("both ratios zero on a nonzero pair");

endmodule

bind gcd_ratio_reducer_top grr_checker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .OUT_DATA_W  (OUT_DATA_W)
) u_grr_checker (.*);
